### src/escaped_command_packet_decoder_defines.svh
// Assertion macros shared by the escaped command packet decoder RTL.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef ESCAPED_COMMAND_PACKET_DECODER_DEFINES_SVH
`define ESCAPED_COMMAND_PACKET_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ECPD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ECPD assertion failed");

// Next-cycle implication, checked outside reset.
`define ECPD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ECPD assertion failed");

`endif

### src/ecpd_pkg.sv
// Package for the escaped command packet decoder: constants, phase type and
// the stage payload struct. No dependencies.
package ecpd_pkg;

   localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
   localparam logic [7:0]  FORCED_BYTE  = 8'hFF;
   localparam logic [7:0]  CMD_LED_ON   = 8'd2;
   localparam logic [7:0]  CMD_LED_OFF  = 8'd3;
   localparam logic [16:0] FULL_SCALE   = 17'd65535;
   localparam logic [15:0] PERIOD_RESET = 16'd1000;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_CMD    = 3'd1,
      PH_HIGH   = 3'd2,
      PH_LOW    = 3'd3,
      PH_ESCAPE = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0]  command;
      logic [15:0] value;
      logic        led_on;
      logic [31:0] product;
   } stage_type;

endpackage

### src/ecpd_duty.sv
// Divides a 32-bit product by 65535 with a shift, an add and one compare.
// Depends on ecpd_pkg.
module ecpd_duty
   import ecpd_pkg::*;
(
   input  logic [31:0] product,
   output logic [15:0] duty
);

   logic [15:0] quot_est;
   logic [16:0] rem_est;

   // product = quot_est*65535 + (quot_est + low half); the remainder estimate
   // stays below twice the divisor, so a single correction suffices.
   always_comb begin
      quot_est = product[31:16];
      rem_est  = {1'b0, quot_est} + {1'b0, product[15:0]};
      duty     = quot_est + {15'd0, (rem_est >= FULL_SCALE)};
   end

endmodule

### src/escaped_command_packet_decoder.sv
// Escaped command packet decoder: takes one received byte per word, finds
// framed five-byte packets and returns command, value, LED flag and PWM duty.
// Depends on ecpd_pkg, ecpd_duty and escaped_command_packet_decoder_defines.svh.
//
// A byte word is accepted every cycle that the result side keeps up. Bytes are
// hunted for the start byte 255, then command, data high, data low and escape
// bytes follow; the escape byte yields one result word via the first stage and
// then the output register. The first stage holds the 16 x 16 multiply
// of value by the PWM period, the second the correction that divides by 65535.
// The period register should be written only while no packet is in flight.
`include "escaped_command_packet_decoder_defines.svh"

module escaped_command_packet_decoder
   import ecpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_command,
   output logic [15:0] rsp_value,
   output logic        rsp_led_on,
   output logic [15:0] rsp_duty_count,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_command_ff;
   logic [7:0]  held_high_ff;
   logic [7:0]  held_low_ff;
   logic        led_flag_ff, led_flag_in;
   logic [15:0] pwm_period_ff;

   logic        req_accept;
   logic        fire;
   logic [15:0] value_in;
   logic [7:0]  high_byte;
   logic [7:0]  low_byte;

   logic        s1_valid_ff;
   stage_type   s1_ff, s1_in;
   logic        s1_load;
   logic        out_free;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_command_ff;
   logic [15:0] rsp_value_ff;
   logic        rsp_led_on_ff;
   logic [15:0] rsp_duty_ff;
   logic [15:0] duty;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || out_free;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && !req_stall;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (req_accept) begin
         unique case (phase_ff)
            PH_CMD:    phase_in = PH_HIGH;
            PH_HIGH:   phase_in = PH_LOW;
            PH_LOW:    phase_in = PH_ESCAPE;
            PH_ESCAPE: phase_in = PH_HUNT;
            default:   phase_in = (req_rx_byte == SYNC_BYTE) ? PH_CMD : PH_HUNT;
         endcase
      end
   end

   // Packet completion on the escape byte.
   always_comb begin
      fire        = req_accept && (phase_ff == PH_ESCAPE);
      high_byte   = req_rx_byte[0] ? FORCED_BYTE : held_high_ff;
      low_byte    = req_rx_byte[1] ? FORCED_BYTE : held_low_ff;
      value_in    = {high_byte, low_byte};
      led_flag_in = led_flag_ff;
      if (fire) begin
         case (held_command_ff)
            CMD_LED_ON:  led_flag_in = 1'b1;
            CMD_LED_OFF: led_flag_in = 1'b0;
            default:     led_flag_in = led_flag_ff;
         endcase
      end
      s1_in.command = held_command_ff;
      s1_in.value   = value_in;
      s1_in.led_on  = led_flag_in;
      s1_in.product = value_in * pwm_period_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         led_flag_ff   <= 1'b0;
         pwm_period_ff <= PERIOD_RESET;
      end else begin
         phase_ff    <= phase_in;
         led_flag_ff <= led_flag_in;
         if (csr_wr_en) begin
            pwm_period_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_command_ff <= 8'd0;
         held_high_ff    <= 8'd0;
         held_low_ff     <= 8'd0;
      end else begin
         if (req_accept && (phase_ff == PH_CMD)) begin
            held_command_ff <= req_rx_byte;
         end
         if (req_accept && (phase_ff == PH_HIGH)) begin
            held_high_ff <= req_rx_byte;
         end
         if (req_accept && (phase_ff == PH_LOW)) begin
            held_low_ff <= req_rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && fire) begin
         s1_ff <= s1_in;
      end
   end

   ecpd_duty u_duty (
      .product (s1_ff.product),
      .duty    (duty)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_command_ff <= s1_ff.command;
         rsp_value_ff   <= s1_ff.value;
         rsp_led_on_ff  <= s1_ff.led_on;
         rsp_duty_ff    <= duty;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_command    = rsp_command_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_led_on     = rsp_led_on_ff;
   assign rsp_duty_count = rsp_duty_ff;

   `ECPD_ASSERT_SAME(a_stall_needs_work, req_stall, s1_valid_ff && rsp_valid_ff)
   `ECPD_ASSERT_NEXT(a_stage_moves, s1_valid_ff && out_free, rsp_valid_ff)
   `ECPD_ASSERT_NEXT(a_led_only_on_packet, !fire, $stable(led_flag_ff))
   `ECPD_ASSERT_NEXT(a_hunt_needs_start, (phase_ff == PH_HUNT) && !(req_accept && (req_rx_byte == SYNC_BYTE)), phase_ff == PH_HUNT)

endmodule

### bench/testbench.sv
// Self-checking bench for the escaped command packet decoder: a scoreboard
// class predicts each packet word from the accepted bytes and checks the output.
// Depends on ecpd_pkg and the escaped_command_packet_decoder RTL.
module testbench;
   import ecpd_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 8;
   localparam int PHASE_BYTES = 130;

   typedef struct packed {
      logic [7:0]  command;
      logic [15:0] value;
      logic        led_on;
      logic [15:0] duty_count;
   } packet_word_type;

   class packet_predictor_type;
      phase_type       phase;
      logic [7:0]      held_command;
      logic [7:0]      held_high;
      logic [7:0]      held_low;
      logic            led_flag;
      logic [15:0]     period;
      packet_word_type expected_packets[$];
      int              errors;

      function new();
         phase        = PH_HUNT;
         held_command = '0;
         held_high    = '0;
         held_low     = '0;
         led_flag     = 1'b0;
         period       = PERIOD_RESET;
         errors       = 0;
      endfunction

      function void take_byte(logic [7:0] b);
         logic [7:0]      hi;
         logic [7:0]      lo;
         logic [31:0]     product;
         packet_word_type word;
         case (phase)
            PH_CMD: begin
               held_command = b;
               phase = PH_HIGH;
            end
            PH_HIGH: begin
               held_high = b;
               phase = PH_LOW;
            end
            PH_LOW: begin
               held_low = b;
               phase = PH_ESCAPE;
            end
            PH_ESCAPE: begin
               hi = b[0] ? FORCED_BYTE : held_high;
               lo = b[1] ? FORCED_BYTE : held_low;
               if (held_command == CMD_LED_ON) begin
                  led_flag = 1'b1;
               end else if (held_command == CMD_LED_OFF) begin
                  led_flag = 1'b0;
               end
               word.command    = held_command;
               word.value      = {hi, lo};
               word.led_on     = led_flag;
               product         = {16'd0, word.value} * {16'd0, period};
               word.duty_count = 16'(product / FULL_SCALE);
               expected_packets.push_back(word);
               phase = PH_HUNT;
            end
            default: begin
               phase = (b == SYNC_BYTE) ? PH_CMD : PH_HUNT;
            end
         endcase
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_packet(packet_word_type got);
         packet_word_type want;
         if (expected_packets.size() == 0) begin
            $display("%0t: word expected none, actual cmd %0h value %0h led %0b duty %0h",
                     $time, got.command, got.value, got.led_on, got.duty_count);
            errors++;
            return;
         end
         want = expected_packets.pop_front();
         compare("command", 16'(want.command), 16'(got.command));
         compare("value", want.value, got.value);
         compare("led_on", 16'(want.led_on), 16'(got.led_on));
         compare("duty_count", want.duty_count, got.duty_count);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_command;
   logic [15:0] rsp_value;
   logic        rsp_led_on;
   logic [15:0] rsp_duty_count;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        no_idle;
   int          quiet_cycles;

   logic [7:0]  opening[27] = '{
      8'h00, 8'hFE,
      8'hFF, 8'h02, 8'h00, 8'h00, 8'h00,
      8'hFF, 8'h03, 8'hFF, 8'hFF, 8'h00,
      8'hFF, 8'h05, 8'h12, 8'h34, 8'h03,
      8'hFF, 8'h02, 8'h80, 8'h01, 8'h01,
      8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h02
   };

   packet_predictor_type model = new();

   escaped_command_packet_decoder u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_command    (rsp_command),
      .rsp_value      (rsp_value),
      .rsp_led_on     (rsp_led_on),
      .rsp_duty_count (rsp_duty_count),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Both channels and the register port are sampled in one place, so that the
   // prediction never depends on the order of processes within a time step.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (csr_wr_en) begin
            model.period = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            model.take_byte(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            model.check_packet({rsp_command, rsp_value, rsp_led_on, rsp_duty_count});
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : result_stall
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!no_idle && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 16);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic maybe_pause();
      int n;
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_packet();
      logic [7:0] cmd;
      logic [7:0] hi;
      logic [7:0] lo;
      case ($urandom_range(0, 5))
         0: cmd = CMD_LED_ON;
         1: cmd = CMD_LED_OFF;
         2: cmd = SYNC_BYTE;
         3: cmd = 8'd0;
         default: cmd = 8'($urandom);
      endcase
      hi = ($urandom_range(0, 7) == 0) ? FORCED_BYTE : 8'($urandom);
      lo = ($urandom_range(0, 7) == 0) ? FORCED_BYTE : 8'($urandom);
      maybe_pause();
      send_byte(SYNC_BYTE);
      maybe_pause();
      send_byte(cmd);
      maybe_pause();
      send_byte(hi);
      maybe_pause();
      send_byte(lo);
      maybe_pause();
      send_byte(8'($urandom));
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 3);
      repeat (n) begin
         maybe_pause();
         if ($urandom_range(0, 7) == 0) begin
            send_byte(SYNC_BYTE);
         end else begin
            send_byte(8'($urandom_range(0, 254)));
         end
      end
   endtask

   // Completes any packet left open, then waits for every expected word and
   // lets the pipeline settle before the period may change.
   task automatic settle();
      int remaining;
      req_valid <= 1'b0;
      @(posedge clock);
      remaining = (model.phase == PH_HUNT) ? 0 : 5 - int'(model.phase);
      repeat (remaining) send_byte(8'($urandom));
      req_valid <= 1'b0;
      while (model.expected_packets.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_period(input logic [15:0] p);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= p;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      logic [15:0] p;
      int          sent;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'd0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 16'd0;
      no_idle     <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) begin
         maybe_pause();
         send_byte(opening[i]);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            case (ph)
               1: p = 16'd65535;
               2: p = 16'd1;
               3: p = 16'd0;
               4: p = 16'd32768;
               7: p = PERIOD_RESET;
               default: p = 16'($urandom_range(1, 65535));
            endcase
            write_period(p);
         end
         if (ph == PHASES - 1) begin
            no_idle <= 1'b1;
         end
         sent = 0;
         while (sent < PHASE_BYTES) begin
            if ($urandom_range(0, 9) < 8) begin
               send_packet();
               sent += 5;
            end else begin
               send_noise();
            end
         end
         settle();
      end

      model.errors += model.expected_packets.size();
      if (model.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
